// ----- design/lhgs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the lift height goal supervisor.
package lhgs_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [10:0] TRANSMIT_ID_RST   = 11'd288;
   localparam logic [10:0] RECEIVE_ID_RST    = 11'd544;
   localparam logic [25:0] MAX_HEIGHT_RST    = 26'd210000;
   localparam logic [25:0] TOLERANCE_RST     = 26'd5000;
   localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd300;

   localparam logic [19:0] ELAPSED_MAX  = 20'hFFFFF;
   localparam logic [26:0] MM_ROUND     = 27'd500;
   localparam logic [27:0] MM_RECIP     = 28'd137438954;
   localparam int          MM_SHIFT     = 37;
   localparam logic [3:0]  MIN_FRAME_LEN = 4'd2;

   typedef enum logic [2:0] {
      CSR_TRANSMIT_ID   = 3'd0,
      CSR_RECEIVE_ID    = 3'd1,
      CSR_MAX_HEIGHT    = 3'd2,
      CSR_TOLERANCE     = 3'd3,
      CSR_TIMEOUT_TICKS = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_ACTION_GOAL = 3'd0,
      CMD_TOPIC_GOAL  = 3'd1,
      CMD_CAN_FRAME   = 3'd2,
      CMD_TICK        = 3'd3,
      CMD_CANCEL      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ACTION = 2'd1,
      MODE_TOPIC  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_FRAME    = 2'd0,
      KIND_STATUS   = 2'd1,
      KIND_FEEDBACK = 2'd2,
      KIND_RESULT   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CODE_REACHED   = 3'd0,
      CODE_OUT_RANGE = 3'd1,
      CODE_BUSY      = 3'd2,
      CODE_TIMEOUT   = 3'd3,
      CODE_CANCELED  = 3'd4
   } code_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [26:0] target_um;
      logic [10:0]        frame_id;
      logic [3:0]         frame_length;
      logic [7:0]         frame_byte_low;
      logic [7:0]         frame_byte_high;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] out_frame_id;
      logic [15:0] level_mm;
      logic        success;
      logic [2:0]  result_code;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [10:0] transmit_id;
      logic [10:0] receive_id;
      logic [25:0] max_height_um;
      logic [25:0] tolerance_um;
      logic [19:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic         load;
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } rsp_pair_type;

   // Rounds micrometres to millimetres by a reciprocal multiply, exact for
   // every 26-bit input, and saturates at the 16-bit range.
   function automatic logic [15:0] to_mm(input logic [25:0] um);
      logic [26:0] rounded;
      logic [54:0] prod;
      logic [17:0] quot;
      rounded = {1'b0, um} + MM_ROUND;
      prod    = 55'(rounded) * 55'(MM_RECIP);
      quot    = prod[54:MM_SHIFT];
      to_mm   = (quot > 18'h0FFFF) ? 16'hFFFF : quot[15:0];
   endfunction

endpackage

// ----- design/lhgs_req_if.sv -----
`timescale 1ns / 1ps
// Request channel interface carrying one input word with valid and ready.
interface lhgs_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic signed [26:0] target_um;
   logic [10:0]        frame_id;
   logic [3:0]         frame_length;
   logic [7:0]         frame_byte_low;
   logic [7:0]         frame_byte_high;

   modport source (output valid, cmd, target_um, frame_id, frame_length,
                   frame_byte_low, frame_byte_high, input ready);
   modport sink (input valid, cmd, target_um, frame_id, frame_length,
                 frame_byte_low, frame_byte_high, output ready);
endinterface

// ----- design/lhgs_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel interface carrying one result word with valid and ready.
interface lhgs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [10:0] out_frame_id;
   logic [15:0] level_mm;
   logic        success;
   logic [2:0]  result_code;
   logic        last;

   modport source (output valid, kind, out_frame_id, level_mm, success,
                   result_code, last, input ready);
   modport sink (input valid, kind, out_frame_id, level_mm, success,
                 result_code, last, output ready);
endinterface

// ----- design/lhgs_csr.sv -----
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module lhgs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lhgs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lhgs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lhgs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output lhgs_pkg::cfg_type               cfg
);

   lhgs_pkg::cfg_type cfg_ff;
   lhgs_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign index  = paddr[4:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            lhgs_pkg::CSR_TRANSMIT_ID:   cfg_in.transmit_id   = pwdata[10:0];
            lhgs_pkg::CSR_RECEIVE_ID:    cfg_in.receive_id    = pwdata[10:0];
            lhgs_pkg::CSR_MAX_HEIGHT:    cfg_in.max_height_um = pwdata[25:0];
            lhgs_pkg::CSR_TOLERANCE:     cfg_in.tolerance_um  = pwdata[25:0];
            lhgs_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         lhgs_pkg::CSR_TRANSMIT_ID:   prdata = 32'(cfg_ff.transmit_id);
         lhgs_pkg::CSR_RECEIVE_ID:    prdata = 32'(cfg_ff.receive_id);
         lhgs_pkg::CSR_MAX_HEIGHT:    prdata = 32'(cfg_ff.max_height_um);
         lhgs_pkg::CSR_TOLERANCE:     prdata = 32'(cfg_ff.tolerance_um);
         lhgs_pkg::CSR_TIMEOUT_TICKS: prdata = 32'(cfg_ff.timeout_ticks);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transmit_id   <= lhgs_pkg::TRANSMIT_ID_RST;
         cfg_ff.receive_id    <= lhgs_pkg::RECEIVE_ID_RST;
         cfg_ff.max_height_um <= lhgs_pkg::MAX_HEIGHT_RST;
         cfg_ff.tolerance_um  <= lhgs_pkg::TOLERANCE_RST;
         cfg_ff.timeout_ticks <= lhgs_pkg::TIMEOUT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/lhgs_core.sv -----
`timescale 1ns / 1ps
// Input register, goal state and the per-word decision logic.
module lhgs_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  lhgs_pkg::req_word_type req_word,
   output logic                   req_ready,
   input  lhgs_pkg::cfg_type      cfg,
   input  logic                   free,
   output lhgs_pkg::rsp_pair_type pair
);

   logic                   in_valid_ff;
   lhgs_pkg::req_word_type in_word_ff;
   lhgs_pkg::mode_type     mode_ff, mode_in;
   logic [25:0]            goal_um_ff, goal_um_in;
   logic [15:0]            goal_mm_ff, goal_mm_in;
   logic [15:0]            measured_ff, measured_in;
   logic [19:0]            elapsed_ff, elapsed_in;
   logic                   cancel_ff, cancel_in;

   logic                   go;
   logic                   in_range;
   logic [15:0]            new_mm;
   logic [19:0]            elapsed_inc;
   logic                   timed_out;
   logic [26:0]            meas_um;
   logic signed [27:0]     err;
   logic [27:0]            err_abs;
   logic                   near_goal;
   lhgs_pkg::rsp_word_type word0, word1;
   logic [1:0]             count;

   assign go        = in_valid_ff && free;
   assign req_ready = !in_valid_ff || go;

   assign in_range = !in_word_ff.target_um[26] &&
                     (in_word_ff.target_um[25:0] <= cfg.max_height_um);
   assign new_mm   = lhgs_pkg::to_mm(in_word_ff.target_um[25:0]);

   assign elapsed_inc = (elapsed_ff == lhgs_pkg::ELAPSED_MAX) ? elapsed_ff
                                                             : elapsed_ff + 20'd1;
   assign timed_out   = elapsed_inc > cfg.timeout_ticks;

   // Measured millimetres times 1000 by shifts and subtracts.
   assign meas_um   = (27'(measured_ff) << 10) - (27'(measured_ff) << 4)
                      - (27'(measured_ff) << 3);
   assign err       = signed'({1'b0, meas_um}) - signed'({2'b0, goal_um_ff});
   assign err_abs   = err[27] ? 28'(-err) : 28'(err);
   assign near_goal = err_abs < {2'b0, cfg.tolerance_um};

   always_comb begin
      lhgs_pkg::rsp_word_type result_w;
      lhgs_pkg::rsp_word_type frame_w;
      lhgs_pkg::rsp_word_type status_w;

      mode_in     = mode_ff;
      goal_um_in  = goal_um_ff;
      goal_mm_in  = goal_mm_ff;
      measured_in = measured_ff;
      elapsed_in  = elapsed_ff;
      cancel_in   = cancel_ff;
      word0       = '0;
      word1       = '0;
      count       = 2'd0;

      result_w              = '0;
      result_w.kind         = lhgs_pkg::KIND_RESULT;
      result_w.level_mm     = measured_ff;
      frame_w               = '0;
      frame_w.kind          = lhgs_pkg::KIND_FRAME;
      frame_w.out_frame_id  = cfg.transmit_id;
      frame_w.level_mm      = goal_mm_ff;
      status_w              = '0;
      status_w.level_mm     = measured_ff;

      case (in_word_ff.cmd)
         lhgs_pkg::CMD_ACTION_GOAL: begin
            elapsed_in = '0;
            count      = 2'd1;
            if (!in_range) begin
               word0             = result_w;
               word0.result_code = lhgs_pkg::CODE_OUT_RANGE;
            end else if (mode_ff != lhgs_pkg::MODE_IDLE) begin
               word0             = result_w;
               word0.result_code = lhgs_pkg::CODE_BUSY;
            end else begin
               mode_in        = lhgs_pkg::MODE_ACTION;
               goal_um_in     = in_word_ff.target_um[25:0];
               goal_mm_in     = new_mm;
               cancel_in      = 1'b0;
               word0          = frame_w;
               word0.level_mm = new_mm;
            end
         end
         lhgs_pkg::CMD_TOPIC_GOAL: begin
            if (in_range && mode_ff == lhgs_pkg::MODE_IDLE) begin
               mode_in        = lhgs_pkg::MODE_TOPIC;
               goal_um_in     = in_word_ff.target_um[25:0];
               goal_mm_in     = new_mm;
               elapsed_in     = '0;
               cancel_in      = 1'b0;
               word0          = frame_w;
               word0.level_mm = new_mm;
               count          = 2'd1;
            end
         end
         lhgs_pkg::CMD_CAN_FRAME: begin
            if (in_word_ff.frame_id == cfg.receive_id &&
                in_word_ff.frame_length >= lhgs_pkg::MIN_FRAME_LEN) begin
               measured_in    = {in_word_ff.frame_byte_high, in_word_ff.frame_byte_low};
               word0          = status_w;
               word0.kind     = lhgs_pkg::KIND_STATUS;
               word0.level_mm = measured_in;
               count          = 2'd1;
            end
         end
         lhgs_pkg::CMD_TICK: begin
            elapsed_in = elapsed_inc;
            if (mode_ff == lhgs_pkg::MODE_ACTION) begin
               if (timed_out) begin
                  mode_in           = lhgs_pkg::MODE_IDLE;
                  cancel_in         = 1'b0;
                  word0             = result_w;
                  word0.result_code = lhgs_pkg::CODE_TIMEOUT;
                  count             = 2'd1;
               end else if (cancel_ff) begin
                  mode_in           = lhgs_pkg::MODE_IDLE;
                  cancel_in         = 1'b0;
                  word0             = result_w;
                  word0.result_code = lhgs_pkg::CODE_CANCELED;
                  count             = 2'd1;
               end else begin
                  word0      = status_w;
                  word0.kind = lhgs_pkg::KIND_FEEDBACK;
                  count      = 2'd2;
                  if (near_goal) begin
                     mode_in           = lhgs_pkg::MODE_IDLE;
                     cancel_in         = 1'b0;
                     word1             = result_w;
                     word1.success     = 1'b1;
                     word1.result_code = lhgs_pkg::CODE_REACHED;
                  end else begin
                     word1 = frame_w;
                  end
               end
            end else if (mode_ff == lhgs_pkg::MODE_TOPIC) begin
               if (timed_out || near_goal) begin
                  mode_in   = lhgs_pkg::MODE_IDLE;
                  cancel_in = 1'b0;
               end else begin
                  word0 = frame_w;
                  count = 2'd1;
               end
            end
         end
         lhgs_pkg::CMD_CANCEL: begin
            if (mode_ff == lhgs_pkg::MODE_ACTION) begin
               cancel_in = 1'b1;
            end
         end
         default: ;
      endcase

      if (count == 2'd1) begin
         word0.last = 1'b1;
      end else if (count == 2'd2) begin
         word1.last = 1'b1;
      end
   end

   assign pair.load  = go;
   assign pair.count = count;
   assign pair.word0 = word0;
   assign pair.word1 = word1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lhgs_pkg::MODE_IDLE;
         goal_um_ff  <= '0;
         goal_mm_ff  <= '0;
         measured_ff <= '0;
         elapsed_ff  <= '0;
         cancel_ff   <= 1'b0;
      end else if (go) begin
         mode_ff     <= mode_in;
         goal_um_ff  <= goal_um_in;
         goal_mm_ff  <= goal_mm_in;
         measured_ff <= measured_in;
         elapsed_ff  <= elapsed_in;
         cancel_ff   <= cancel_in;
      end
   end

endmodule

// ----- design/lhgs_rsp_buf.sv -----
`timescale 1ns / 1ps
// Two-slot result register that hands out the words of one input in order.
module lhgs_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  lhgs_pkg::rsp_pair_type pair,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lhgs_pkg::rsp_word_type rsp_word
);

   logic [1:0]             cnt_ff, cnt_in;
   lhgs_pkg::rsp_word_type slot0_ff, slot0_in;
   lhgs_pkg::rsp_word_type slot1_ff, slot1_in;
   logic                   pop;

   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_word  = slot0_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (pair.load && pair.count != 2'd0) begin
         cnt_in   = pair.count;
         slot0_in = pair.word0;
         slot1_in = pair.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ----- design/lift_height_goal_supervisor_unit.sv -----
`timescale 1ns / 1ps
// Top level of the lift height goal supervisor.
// A word is registered at acceptance; its results are loaded into the result
// register once that is free and offered in order. Throughput: one input word
// per cycle while each gives at most one result and the result port is not
// stalled; a tick with two result words holds the result register until both
// are taken. Reset clears the goal state, empties the input and result
// registers and restores the configuration registers to their defaults.
module lift_height_goal_supervisor_unit (
   input  logic                            clock,
   input  logic                            reset,
   lhgs_req_if.sink                        req_port,
   lhgs_rsp_if.source                      rsp_port,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lhgs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lhgs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lhgs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   lhgs_pkg::cfg_type      cfg;
   lhgs_pkg::req_word_type req_word;
   lhgs_pkg::rsp_word_type rsp_word;
   lhgs_pkg::rsp_pair_type pair;
   logic                   free;

   assign req_word.cmd             = req_port.cmd;
   assign req_word.target_um       = req_port.target_um;
   assign req_word.frame_id        = req_port.frame_id;
   assign req_word.frame_length    = req_port.frame_length;
   assign req_word.frame_byte_low  = req_port.frame_byte_low;
   assign req_word.frame_byte_high = req_port.frame_byte_high;

   assign rsp_port.kind         = rsp_word.kind;
   assign rsp_port.out_frame_id = rsp_word.out_frame_id;
   assign rsp_port.level_mm     = rsp_word.level_mm;
   assign rsp_port.success      = rsp_word.success;
   assign rsp_port.result_code  = rsp_word.result_code;
   assign rsp_port.last         = rsp_word.last;

   lhgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lhgs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_word  (req_word),
      .req_ready (req_port.ready),
      .cfg       (cfg),
      .free      (free),
      .pair      (pair)
   );

   lhgs_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .free      (free),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- design/lhgs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the supervisor and its bind to the top level.
module lhgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [10:0] rsp_out_frame_id,
   input logic        rsp_success,
   input logic [2:0]  rsp_result_code
);

   // A stalled result word stays offered with its kind and result code unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_result_code))
      else $error("stalled result word changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   // Only action results carry a success flag or a result code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != lhgs_pkg::KIND_RESULT |->
         !rsp_success && rsp_result_code == lhgs_pkg::CODE_REACHED)
      else $error("result fields set on a non-result word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != lhgs_pkg::KIND_FRAME |-> rsp_out_frame_id == 11'd0)
      else $error("frame identifier set on a non-frame word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |->
         rsp_kind == lhgs_pkg::KIND_RESULT && rsp_result_code == lhgs_pkg::CODE_REACHED)
      else $error("success reported without a reached result");

endmodule

bind lift_height_goal_supervisor_unit lhgs_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_kind         (rsp_port.kind),
   .rsp_out_frame_id (rsp_port.out_frame_id),
   .rsp_success      (rsp_port.success),
   .rsp_result_code  (rsp_port.result_code)
);

// ----- tb/sv/lift_height_goal_supervisor_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking test of the lift height goal supervisor: directed rows, then random traffic.
module lift_height_goal_supervisor_unit_test;
   import lhgs_pkg::*;

   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam logic [3:0] FRAME_LEN_MIN = 4'd2;
   localparam cfg_type BOOT_CFG = '{11'd288, 11'd544, 26'd210000, 26'd5000, 20'd300};
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 187;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      req_word_type word;
      bit           typed;
      int           count;
      rsp_word_type want0;
      rsp_word_type want1;
   } drill_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   lhgs_req_if req_if();
   lhgs_rsp_if rsp_if();

   lift_height_goal_supervisor_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_port(req_if),
      .rsp_port(rsp_if),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   cfg_type      shadow_cfg = BOOT_CFG;
   mode_type     lift_mode = MODE_IDLE;
   logic [25:0]  aim_um = '0;
   logic [15:0]  height_now_mm = '0;
   logic [19:0]  tick_count = '0;
   logic         stop_asked = 1'b0;
   rsp_word_type awaited_words[$];
   rsp_word_type blank = '0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           idle_on = 1'b0;
   bit           hold_asked = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] um_to_mm(input logic [25:0] um);
      longint q;
      q = (longint'(um) + 500) / 1000;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic bit close_enough();
      longint err;
      err = longint'(height_now_mm) * 1000 - longint'(aim_um);
      if (err < 0) err = -err;
      return err < longint'(shadow_cfg.tolerance_um);
   endfunction

   function automatic rsp_word_type res(input kind_type kind, input logic [10:0] fid,
                                        input logic [15:0] mm, input logic ok,
                                        input logic [2:0] code, input logic last);
      rsp_word_type r;
      r.kind = kind;
      r.out_frame_id = fid;
      r.level_mm = mm;
      r.success = ok;
      r.result_code = code;
      r.last = last;
      return r;
   endfunction

   function automatic rsp_word_type frame_word();
      return res(KIND_FRAME, shadow_cfg.transmit_id, um_to_mm(aim_um), 1'b0, '0, 1'b0);
   endfunction

   function automatic rsp_word_type end_word(input logic ok, input code_type code);
      return res(KIND_RESULT, '0, height_now_mm, ok, code, 1'b0);
   endfunction

   function automatic void drop_goal();
      lift_mode = MODE_IDLE;
      stop_asked = 1'b0;
   endfunction

   function automatic void step_supervisor(input req_word_type w, output int n,
                                           output rsp_word_type outw[2]);
      logic signed [26:0] t;
      bit in_range;
      t = w.target_um;
      in_range = (t >= 0) && (longint'(t) <= longint'(shadow_cfg.max_height_um));
      n = 0;
      outw[0] = '0;
      outw[1] = '0;
      case (w.cmd)
         CMD_ACTION_GOAL: begin
            tick_count = '0;
            if (!in_range) begin
               outw[n] = end_word(1'b0, CODE_OUT_RANGE);
               n++;
            end else if (lift_mode != MODE_IDLE) begin
               outw[n] = end_word(1'b0, CODE_BUSY);
               n++;
            end else begin
               lift_mode = MODE_ACTION;
               aim_um = t[25:0];
               stop_asked = 1'b0;
               outw[n] = frame_word();
               n++;
            end
         end
         CMD_TOPIC_GOAL: begin
            if (in_range && lift_mode == MODE_IDLE) begin
               lift_mode = MODE_TOPIC;
               aim_um = t[25:0];
               tick_count = '0;
               stop_asked = 1'b0;
               outw[n] = frame_word();
               n++;
            end
         end
         CMD_CAN_FRAME: begin
            if (w.frame_id == shadow_cfg.receive_id && w.frame_length >= FRAME_LEN_MIN) begin
               height_now_mm = {w.frame_byte_high, w.frame_byte_low};
               outw[n] = res(KIND_STATUS, '0, height_now_mm, 1'b0, '0, 1'b0);
               n++;
            end
         end
         CMD_TICK: begin
            if (!(&tick_count)) tick_count++;
            if (lift_mode == MODE_ACTION) begin
               if (tick_count > shadow_cfg.timeout_ticks) begin
                  drop_goal();
                  outw[n] = end_word(1'b0, CODE_TIMEOUT);
                  n++;
               end else if (stop_asked) begin
                  drop_goal();
                  outw[n] = end_word(1'b0, CODE_CANCELED);
                  n++;
               end else begin
                  outw[n] = res(KIND_FEEDBACK, '0, height_now_mm, 1'b0, '0, 1'b0);
                  n++;
                  if (close_enough()) begin
                     drop_goal();
                     outw[n] = end_word(1'b1, CODE_REACHED);
                  end else begin
                     outw[n] = frame_word();
                  end
                  n++;
               end
            end else if (lift_mode == MODE_TOPIC) begin
               if (tick_count > shadow_cfg.timeout_ticks || close_enough()) begin
                  drop_goal();
               end else begin
                  outw[n] = frame_word();
                  n++;
               end
            end
         end
         CMD_CANCEL: begin
            if (lift_mode == MODE_ACTION) stop_asked = 1'b1;
         end
         default: ;
      endcase
      if (n > 0) outw[n-1].last = 1'b1;
   endfunction

   function automatic req_word_type req(input logic [2:0] cmd, input longint target,
                                        input logic [10:0] fid, input logic [3:0] len,
                                        input logic [7:0] lo, input logic [7:0] hi);
      req_word_type w;
      w.cmd = cmd;
      w.target_um = target[26:0];
      w.frame_id = fid;
      w.frame_length = len;
      w.frame_byte_low = lo;
      w.frame_byte_high = hi;
      return w;
   endfunction

   function automatic drill_row_type row(input req_word_type w, input bit typed, input int n,
                                         input rsp_word_type a, input rsp_word_type b);
      drill_row_type r;
      r.word = w;
      r.typed = typed;
      r.count = n;
      r.want0 = a;
      r.want1 = b;
      return r;
   endfunction

   function automatic req_word_type draw_word();
      req_word_type w;
      int pick;
      int h;
      longint span;
      longint t;
      w.cmd = CMD_TICK;
      w.target_um = 27'($urandom);
      w.frame_id = 11'($urandom);
      w.frame_length = 4'($urandom);
      w.frame_byte_low = 8'($urandom);
      w.frame_byte_high = 8'($urandom);
      span = shadow_cfg.max_height_um;
      pick = $urandom_range(0, 99);
      if (pick < 9) w.cmd = CMD_ACTION_GOAL;
      else if (pick < 14) w.cmd = CMD_TOPIC_GOAL;
      else if (pick < 40) w.cmd = CMD_CAN_FRAME;
      else if (pick < 88) w.cmd = CMD_TICK;
      else if (pick < 95) w.cmd = CMD_CANCEL;
      else w.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      if (w.cmd == CMD_ACTION_GOAL || w.cmd == CMD_TOPIC_GOAL) begin
         case ($urandom_range(0, 9))
            0: t = longint'($urandom);
            1: t = span + $urandom_range(1, 2000);
            2: t = ($urandom_range(0, 1) != 0) ? span : 0;
            3: t = longint'($urandom_range(0, 32'(span / 1000))) * 1000;
            default: t = $urandom_range(0, 32'(span));
         endcase
         w.target_um = t[26:0];
      end
      if (w.cmd == CMD_CAN_FRAME) begin
         if ($urandom_range(0, 9) != 0) w.frame_id = shadow_cfg.receive_id;
         if ($urandom_range(0, 4) != 0) w.frame_length = 4'($urandom_range(2, 8));
         if (lift_mode != MODE_IDLE && $urandom_range(0, 2) != 0) begin
            h = int'(um_to_mm(aim_um)) + $urandom_range(0, 12) - 6;
            if (h < 0) h = 0;
            if (h > 65535) h = 65535;
            w.frame_byte_low = h[7:0];
            w.frame_byte_high = h[15:8];
         end
      end
      return w;
   endfunction

   function automatic string word_text(input rsp_word_type r);
      return $sformatf("kind %0d id %0d mm %0d success %0d code %0d last %0d",
                       r.kind, r.out_frame_id, r.level_mm, r.success, r.result_code, r.last);
   endfunction

   function automatic void flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", what);
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind = rsp_if.kind;
         got.out_frame_id = rsp_if.out_frame_id;
         got.level_mm = rsp_if.level_mm;
         got.success = rsp_if.success;
         got.result_code = rsp_if.result_code;
         got.last = rsp_if.last;
         if (awaited_words.size() == 0) begin
            flag_mismatch({"result word with none expected: ", word_text(got)});
         end else begin
            want = awaited_words.pop_front();
            if (got.kind !== want.kind || got.out_frame_id !== want.out_frame_id ||
                got.level_mm !== want.level_mm || got.success !== want.success ||
                got.result_code !== want.result_code || got.last !== want.last)
               flag_mismatch({"result word mismatch, expected ", word_text(want),
                              ", got ", word_text(got)});
         end
      end
   end

   initial begin : rsp_drain
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic offer(input req_word_type w, input bit use_typed, input int typed_n,
                        input rsp_word_type typed0, input rsp_word_type typed1);
      int n;
      rsp_word_type outw[2];
      req_if.valid <= 1'b1;
      req_if.cmd <= w.cmd;
      req_if.target_um <= w.target_um;
      req_if.frame_id <= w.frame_id;
      req_if.frame_length <= w.frame_length;
      req_if.frame_byte_low <= w.frame_byte_low;
      req_if.frame_byte_high <= w.frame_byte_high;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      step_supervisor(w, n, outw);
      if (use_typed) begin
         if (typed_n > 0) awaited_words.push_back(typed0);
         if (typed_n > 1) awaited_words.push_back(typed1);
      end else begin
         for (int i = 0; i < n; i++) awaited_words.push_back(outw[i]);
      end
   endtask

   task automatic pause_sender();
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_TRANSMIT_ID:   shadow_cfg.transmit_id = value[10:0];
         CSR_RECEIVE_ID:    shadow_cfg.receive_id = value[10:0];
         CSR_MAX_HEIGHT:    shadow_cfg.max_height_um = value[25:0];
         CSR_TOLERANCE:     shadow_cfg.tolerance_um = value[25:0];
         CSR_TIMEOUT_TICKS: shadow_cfg.timeout_ticks = value[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   initial begin : stimulus
      drill_row_type drills[$];
      cfg_type plan[PHASES];
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd <= CMD_TICK;
      req_if.target_um <= '0;
      req_if.frame_id <= '0;
      req_if.frame_length <= '0;
      req_if.frame_byte_low <= '0;
      req_if.frame_byte_high <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_CANCEL, 0, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_UNUSED_LO, 0, 544, 2, 1, 1), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_UNUSED_HI, 1000, 544, 2, 1, 1), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_ACTION_GOAL, -1, 0, 0, 0, 0), 1, 1,
                           res(KIND_RESULT, 0, 0, 0, CODE_OUT_RANGE, 1), blank));
      drills.push_back(row(req(CMD_ACTION_GOAL, 210001, 0, 0, 0, 0), 1, 1,
                           res(KIND_RESULT, 0, 0, 0, CODE_OUT_RANGE, 1), blank));
      drills.push_back(row(req(CMD_TOPIC_GOAL, -67108864, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_TOPIC_GOAL, 67108863, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_CAN_FRAME, 0, 544, 1, 8'hFF, 8'hFF), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_CAN_FRAME, 0, 2047, 15, 8'hFF, 8'hFF), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_CAN_FRAME, 0, 544, 15, 8'h34, 8'h12), 1, 1,
                           res(KIND_STATUS, 0, 4660, 0, 0, 1), blank));
      drills.push_back(row(req(CMD_ACTION_GOAL, 0, 0, 0, 0, 0), 1, 1,
                           res(KIND_FRAME, 288, 0, 0, 0, 1), blank));
      drills.push_back(row(req(CMD_ACTION_GOAL, 100000, 0, 0, 0, 0), 1, 1,
                           res(KIND_RESULT, 0, 4660, 0, CODE_BUSY, 1), blank));
      drills.push_back(row(req(CMD_TOPIC_GOAL, 1000, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 1, 2,
                           res(KIND_FEEDBACK, 0, 4660, 0, 0, 0),
                           res(KIND_FRAME, 288, 0, 0, 0, 1)));
      drills.push_back(row(req(CMD_CANCEL, 0, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 1, 1,
                           res(KIND_RESULT, 0, 4660, 0, CODE_CANCELED, 1), blank));
      drills.push_back(row(req(CMD_CANCEL, 0, 0, 0, 0, 0), 1, 0, blank, blank));
      drills.push_back(row(req(CMD_CAN_FRAME, 0, 544, 2, 8'hFF, 8'hFF), 1, 1,
                           res(KIND_STATUS, 0, 65535, 0, 0, 1), blank));
      drills.push_back(row(req(CMD_ACTION_GOAL, 210000, 0, 0, 0, 0), 1, 1,
                           res(KIND_FRAME, 288, 210, 0, 0, 1), blank));
      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 1, 2,
                           res(KIND_FEEDBACK, 0, 65535, 0, 0, 0),
                           res(KIND_FRAME, 288, 210, 0, 0, 1)));
      drills.push_back(row(req(CMD_CAN_FRAME, 0, 544, 8, 8'hD2, 8'h00), 1, 1,
                           res(KIND_STATUS, 0, 210, 0, 0, 1), blank));
      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 1, 2,
                           res(KIND_FEEDBACK, 0, 210, 0, 0, 0),
                           res(KIND_RESULT, 0, 210, 1, CODE_REACHED, 1)));
      drills.push_back(row(req(CMD_TOPIC_GOAL, 104500, 0, 0, 0, 0), 0, 0, blank, blank));
      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 0, 0, blank, blank));
      drills.push_back(row(req(CMD_CAN_FRAME, 0, 544, 2, 8'h69, 8'h00), 0, 0, blank, blank));
      drills.push_back(row(req(CMD_TICK, 0, 0, 0, 0, 0), 0, 0, blank, blank));

      plan[0] = BOOT_CFG;
      plan[1] = '{11'd1, 11'd2047, 26'd65535000, 26'd1, 20'd1};
      plan[2] = '{11'd2047, 11'd1, 26'd1, 26'd65535000, 20'hFFFFF};
      plan[3] = '{11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047)),
                  26'h3FFFFFF, 26'd3000, 20'd4};
      plan[4] = '{11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047)),
                  26'($urandom_range(1000, 65535000)), 26'($urandom_range(1, 20000)),
                  20'($urandom_range(2, 40))};
      plan[5] = BOOT_CFG;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      foreach (drills[i]) begin
         offer(drills[i].word, drills[i].typed, drills[i].count,
               drills[i].want0, drills[i].want1);
         pause_sender();
      end
      settle_block();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            write_csr(CSR_TRANSMIT_ID, 32'(plan[ph].transmit_id));
            write_csr(CSR_RECEIVE_ID, 32'(plan[ph].receive_id));
            write_csr(CSR_MAX_HEIGHT, 32'(plan[ph].max_height_um));
            write_csr(CSR_TOLERANCE, 32'(plan[ph].tolerance_um));
            write_csr(CSR_TIMEOUT_TICKS, 32'(plan[ph].timeout_ticks));
         end
         if (ph == 1) hold_asked = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 40 == 0) idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (i == ITEMS_PER_PHASE / 2) settle_block();
            offer(draw_word(), 0, 0, blank, blank);
            pause_sender();
         end
         settle_block();
      end

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/lhgs_pkg.sv
design/lhgs_req_if.sv
design/lhgs_rsp_if.sv
design/lhgs_csr.sv
design/lhgs_core.sv
design/lhgs_rsp_buf.sv
design/lift_height_goal_supervisor_unit.sv
design/lhgs_checker.sv
tb/sv/lift_height_goal_supervisor_unit_test.sv
